// ----- rtl/nsfc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsfc_pkg
// Shared types and constants for the NMEA sentence framer and checker:
// character codes, field widths, byte kinds, result status codes, the queued word and queue status.
// ----------------------------------------------------------------------------
package nsfc_pkg;

    // Character codes
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Widths of the result fields and the packed output word
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 7;
    localparam int CSUM_W   = 8;
    localparam int RES_W    = STATUS_W + LEN_W + CSUM_W;
    localparam int RES_TDATA_W = ((RES_W + 7) / 8) * 8;

    // Kind of a received byte, set by the front end
    typedef enum logic [1:0] {
        K_OTHER   = 2'd0,
        K_DOLLAR  = 2'd1,
        K_NEWLINE = 2'd2,
        K_STAR    = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_NO_STAR  = 3'd2,
        ST_BAD_HEX  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    // Classified byte, as it travels through the queue
    typedef struct packed {
        t_kind      kind;
        logic       hex_ok;   // byte is 0-9, a-f or A-F
        logic [3:0] hex_val;  // digit value when hex_ok
        logic [7:0] data;     // raw byte
    } t_item;

    // Queue status seen by the front end, the parser and the checks
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- rtl/nmea_sentence_framer_checker_unit.sv -----
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker_unit
// NMEA 0183 sentence framer with checksum check.
// ----------------------------------------------------------------------------
// Input stream: one received byte per word on i_s_tdata. '$' opens or
// restarts a sentence; bytes outside a sentence are dropped. The XOR of the
// bytes between '$' and the first '*' is compared to the two hex digits
// after the '*'. A newline closes the sentence and yields one result word.
// A sentence that passes MAX_LINE-1 stored characters is dropped with an
// overflow status.
// Output stream: one word per closed or dropped sentence, holding status,
// length ('$' included, newline excluded) and computed checksum.
// Throughput: one byte per cycle while the queue has room. A closing byte
// is written into the queue at acceptance, then parsed from the queue head
// into the output register once that register is free or being taken.
// A classifying front end feeds a FIFO_DEPTH-entry queue; the parser pops
// one word a cycle while its result register is free or being taken.
// When the receiver stalls, the result register holds, the queue fills,
// and o_s_tready drops once the queue is full.
// Reset (synchronous, active low) closes any open sentence, empties the
// queue and drops a pending result.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker_unit #(
    parameter int MAX_LINE   = 128,
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [nsfc_pkg::RES_TDATA_W-1:0] o_m_tdata
    // o_m_tdata: [2:0] status, [9:3] sentence_length,
    //            [17:10] computed_checksum, rest zero
);

    nsfc_pkg::t_q_stat w_q_stat;
    nsfc_pkg::t_item   w_in_item;
    nsfc_pkg::t_item   w_q_item;
    logic              w_push;
    logic              w_pop;
    logic [$clog2(FIFO_DEPTH+1)-1:0] w_q_count;

    nsfc_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_item     (w_in_item)
    );

    nsfc_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat),
        .o_count (w_q_count)
    );

    nsfc_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_item     (w_q_item),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Queue never holds more than its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH))
        else $error("queue fill level above depth");

    // Parser never pops an empty queue
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    // Input is held off only when the queue is full
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> w_q_stat.full)
        else $error("input stalled with room in queue");

    // A stalled result blocks the parser
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !w_pop)
        else $error("parser advanced over a stalled result");

    // Result status is a defined code
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= 3'd4))
        else $error("undefined result status");

endmodule

// ----- rtl/nsfc_front.sv -----
// ----------------------------------------------------------------------------
// nsfc_front
// Input side: takes bytes from the stream, classifies each one (frame marks,
// hex digit value) and pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module nsfc_front (
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,
    input  nsfc_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output nsfc_pkg::t_item  o_item
);

    logic [7:0] w_b;
    logic       w_is_num;
    logic       w_is_upper;
    logic       w_is_lower;

    assign w_b = i_s_tdata;

    // Accept whenever the queue has room
    assign o_s_tready = !i_q_stat.full;
    assign o_push     = i_s_tvalid && !i_q_stat.full;

    // Hex digit ranges
    assign w_is_num   = (w_b >= 8'h30) && (w_b <= 8'h39);
    assign w_is_upper = (w_b >= 8'h41) && (w_b <= 8'h46);
    assign w_is_lower = (w_b >= 8'h61) && (w_b <= 8'h66);

    // Classify the byte
    always_comb begin
        o_item.data   = w_b;
        o_item.hex_ok = w_is_num || w_is_upper || w_is_lower;
        if (w_is_num) begin
            o_item.hex_val = w_b[3:0];
        end else if (w_is_upper || w_is_lower) begin
            // 'A'/'a' low nibble is 1, value is low nibble + 9
            o_item.hex_val = w_b[3:0] + 4'd9;
        end else begin
            o_item.hex_val = 4'd0;
        end
        unique case (w_b)
            nsfc_pkg::CH_DOLLAR:  o_item.kind = nsfc_pkg::K_DOLLAR;
            nsfc_pkg::CH_NEWLINE: o_item.kind = nsfc_pkg::K_NEWLINE;
            nsfc_pkg::CH_STAR:    o_item.kind = nsfc_pkg::K_STAR;
            default:              o_item.kind = nsfc_pkg::K_OTHER;
        endcase
    end

endmodule

// ----- rtl/nsfc_queue.sv -----
// ----------------------------------------------------------------------------
// nsfc_queue
// Short first-in first-out queue of classified bytes between the front end
// and the parser. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module nsfc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nsfc_pkg::t_item   i_item,
    input  logic              i_pop,
    output nsfc_pkg::t_item   o_item,
    output nsfc_pkg::t_q_stat o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    nsfc_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_push;
    logic            w_pop;

    assign w_push = i_push && (r_count != FULL);
    assign w_pop  = i_pop && (r_count != '0);

    // Pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_count      = r_count;

endmodule

// ----- rtl/nsfc_back.sv -----
// ----------------------------------------------------------------------------
// nsfc_back
// Sentence parser: tracks the open sentence, its length, running XOR and
// the received checksum digits, and drives the result register.
// ----------------------------------------------------------------------------
module nsfc_back #(
    parameter int MAX_LINE = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  nsfc_pkg::t_q_stat i_q_stat,
    input  nsfc_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [nsfc_pkg::RES_TDATA_W-1:0] o_m_tdata
);

    localparam int CW = $clog2(MAX_LINE);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_LINE - 1);
    localparam int PAD_W = nsfc_pkg::RES_TDATA_W - nsfc_pkg::RES_W;

    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_DIG1 = 2'd1,
        PH_DIG2 = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // Sentence state
    logic          r_in, n_in;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_xor, n_xor;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_rcv, n_rcv;
    logic          r_herr, n_herr;

    // Result register
    logic              r_out_valid, n_out_valid;
    nsfc_pkg::t_status r_status, n_status;
    logic [6:0]        r_len, n_len;
    logic [7:0]        r_csum, n_csum;

    logic              w_emit;
    logic [CW+6:0]     w_cnt_ext;

    // Pop when the result slot is free or being emptied
    assign o_pop = !i_q_stat.empty && (!r_out_valid || i_m_tready);

    // Length field is the count masked to 7 bits
    assign w_cnt_ext = {7'd0, r_cnt};

    always_comb begin
        n_in     = r_in;
        n_cnt    = r_cnt;
        n_xor    = r_xor;
        n_phase  = r_phase;
        n_rcv    = r_rcv;
        n_herr   = r_herr;
        w_emit   = 1'b0;
        n_status = r_status;
        n_len    = r_len;
        n_csum   = r_csum;
        if (o_pop) begin
            if (i_item.kind == nsfc_pkg::K_DOLLAR) begin
                // start or restart a sentence
                n_in    = 1'b1;
                n_cnt   = CW'(1);
                n_xor   = '0;
                n_phase = PH_DATA;
                n_rcv   = '0;
                n_herr  = 1'b0;
            end else if (r_in) begin
                if (i_item.kind == nsfc_pkg::K_NEWLINE ||
                    r_cnt >= LIMIT) begin
                    w_emit = 1'b1;
                    n_len  = w_cnt_ext[6:0];
                    n_csum = r_xor;
                    if (i_item.kind != nsfc_pkg::K_NEWLINE) begin
                        n_status = nsfc_pkg::ST_OVERFLOW;
                    end else if (r_phase == PH_DATA) begin
                        n_status = nsfc_pkg::ST_NO_STAR;
                    end else if (r_phase != PH_DONE || r_herr) begin
                        n_status = nsfc_pkg::ST_BAD_HEX;
                    end else if (r_rcv != r_xor) begin
                        n_status = nsfc_pkg::ST_MISMATCH;
                    end else begin
                        n_status = nsfc_pkg::ST_OK;
                    end
                    n_in    = 1'b0;
                    n_cnt   = '0;
                    n_xor   = '0;
                    n_phase = PH_DATA;
                    n_rcv   = '0;
                    n_herr  = 1'b0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    unique case (r_phase)
                        PH_DATA: begin
                            if (i_item.kind == nsfc_pkg::K_STAR) begin
                                n_phase = PH_DIG1;
                            end else begin
                                n_xor = r_xor ^ i_item.data;
                            end
                        end
                        PH_DIG1, PH_DIG2: begin
                            if (i_item.hex_ok) begin
                                n_rcv = {r_rcv[3:0], i_item.hex_val};
                            end else begin
                                n_herr = 1'b1;
                            end
                            n_phase = (r_phase == PH_DIG1) ? PH_DIG2 : PH_DONE;
                        end
                        default: ;  // trailing bytes only counted
                    endcase
                end
            end
        end
        // result slot
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in        <= 1'b0;
            r_cnt       <= '0;
            r_xor       <= '0;
            r_phase     <= PH_DATA;
            r_rcv       <= '0;
            r_herr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in        <= n_in;
            r_cnt       <= n_cnt;
            r_xor       <= n_xor;
            r_phase     <= n_phase;
            r_rcv       <= n_rcv;
            r_herr      <= n_herr;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_len    <= n_len;
        r_csum   <= n_csum;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_csum, r_len, r_status};

endmodule
